// ===== src/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types and constants of the nearest-sample resampler.
// ----------------------------------------------------------------------------
package nsr_pkg;

	// word widths fixed by the register map and the sample format
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned STEP_W      = 16;
	localparam int unsigned OUT_COUNT_W = 24;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned CFG_IDX_W   = 2;

	// defaults for the top-level parameters
	localparam int unsigned COUNT_BITS_DEF  = 24;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// smallest step honoured; anything below is raised to it
	localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(4);
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAC_STEP  = 2'd0,
		REG_OUT_COUNT  = 2'd1,
		REG_IN_WIDE    = 2'd2,
		REG_OUT_NARROW = 2'd3
	} nsr_reg_t;

	// configuration as seen by front and back
	typedef struct packed {
		logic [STEP_W-1:0]      frac_step;
		logic [OUT_COUNT_W-1:0] out_count;
		logic                   in_wide;
		logic                   out_narrow;
	} nsr_cfg_t;

	// head of the sample queue, front to back
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
	} nsr_q_t;

endpackage

// ===== src/nsr_if.sv =====
// ----------------------------------------------------------------------------
// nsr_in_if / nsr_out_if
// Valid/ready channels carrying source samples in and resampled words out.
// ----------------------------------------------------------------------------
interface nsr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink   (input valid, input in_sample, output ready);
endinterface

interface nsr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_sample;
	logic               last;

	modport source (output valid, output out_sample, output last, input ready);
	modport sink   (input valid, input out_sample, input last, output ready);
endinterface

// ===== src/nsr_front.sv =====
// ----------------------------------------------------------------------------
// nsr_front
// Accepts source words, converts them to the output format and queues them.
// ----------------------------------------------------------------------------
module nsr_front
	import nsr_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  nsr_cfg_t cfg,
	nsr_in_if.sink   samples,
	output nsr_q_t   q,
	input  logic     pop
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic signed [SAMPLE_W-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [CNT_W-1:0]           fill_q;
	logic signed [SAMPLE_W-1:0] wide;
	logic signed [SAMPLE_W-1:0] conv;
	logic                       push;
	logic                       take;

	// widen to signed 16 bits: 8-bit input is offset binary in the low byte
	always_comb begin
		if (cfg.in_wide) begin
			wide = samples.in_sample;
		end else begin
			wide = {~samples.in_sample[7], samples.in_sample[6:0], 8'h00};
		end
	end

	// optional narrowing, arithmetic shift right by a byte
	assign conv = cfg.out_narrow ? {{8{wide[15]}}, wide[15:8]} : wide;

	assign samples.ready = (fill_q != CNT_FULL);
	assign push          = samples.valid && samples.ready;
	assign take          = pop && (fill_q != '0);

	assign q.valid  = (fill_q != '0);
	assign q.sample = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= conv;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				fill_q <= fill_q + 1'b1;
			end else if (take && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/nsr_back.sv =====
// ----------------------------------------------------------------------------
// nsr_back
// Walks the output position against the source index, emitting one word a
// cycle into the output register while it is free, and retires each queued sample.
// ----------------------------------------------------------------------------
module nsr_back
	import nsr_pkg::*;
#(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  nsr_cfg_t cfg,
	input  nsr_q_t   q,
	output logic     pop,
	nsr_out_if.source results
);

	localparam int unsigned POS_W = COUNT_BITS + 16;
	localparam int unsigned CMP_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

	logic [POS_W-1:0]      pos_q;
	logic [COUNT_BITS-1:0] idx_q;
	logic [COUNT_BITS-1:0] emitted_q;
	logic                  out_valid_q;
	logic signed [15:0]    out_sample_q;
	logic                  out_last_q;

	logic [STEP_W-1:0]     step;
	logic [POS_W-1:0]      pos_nx;
	logic [COUNT_BITS-1:0] emitted_nx;
	logic [CMP_W-1:0]      limit;
	logic                  match_now;
	logic                  match_nx;
	logic                  emit_now;
	logic                  out_free;
	logic                  fire;
	logic                  cont;

	assign step       = (cfg.frac_step < STEP_MIN) ? STEP_MIN : cfg.frac_step;
	assign pos_nx     = pos_q + POS_W'(step);
	assign emitted_nx = emitted_q + 1'b1;
	assign limit      = CMP_W'(cfg.out_count);

	// integer part of the position against the current source index
	assign match_now = (pos_q[POS_W-1:8] == {8'h00, idx_q});
	assign match_nx  = (pos_nx[POS_W-1:8] == {8'h00, idx_q});

	assign emit_now = q.valid && (CMP_W'(emitted_q) < limit) && match_now;
	assign out_free = !out_valid_q || results.ready;
	assign fire     = emit_now && out_free;

	// would the following word still belong to this sample
	assign cont = (CMP_W'(emitted_nx) < limit) && match_nx;

	// retire the sample with its last word, or at once if it gives none
	assign pop = q.valid && (!emit_now || (fire && !cont));

	assign results.valid      = out_valid_q;
	assign results.out_sample = out_sample_q;
	assign results.last       = out_last_q;

	// output word register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_sample_q <= q.sample;
			out_last_q   <= (CMP_W'(emitted_nx) == limit);
		end
	end

	// position, index, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			idx_q       <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pos_q     <= pos_nx;
				emitted_q <= emitted_nx;
			end
			if (pop) begin
				idx_q <= idx_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/nearest_sample_resampler.sv =====
// ----------------------------------------------------------------------------
// nearest_sample_resampler
// Nearest-neighbour sample rate converter with an 8.8 fixed-point step.
// ----------------------------------------------------------------------------
// Source words enter on the samples channel, one mono sample per word, and
// resampled words leave on the results channel; both are valid/ready and a
// word moves when valid and ready are high at a rising edge. Registers are
// written through cfg_we/cfg_index/cfg_data while the block is idle.
// Each source sample is converted on entry and queued; the back end then
// emits one result word per cycle, while the output register is free, for
// every output position falling on that sample, the final word of the
// programmed count flagged last. A sample holds the back end until its
// last word is emitted, or is retired at once if it yields none; the
// limit is the single position adder stepping once per word.
// A taken word is queued, and its first result is then registered at the output.
// Reset clears the position, source index and word count and empties the
// queue and output register; registers return to step 256, count 0.
// A stalled receiver holds the output word; the queue keeps taking
// source words until it is full.
// ----------------------------------------------------------------------------
module nearest_sample_resampler
	import nsr_pkg::*;
#(
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	nsr_in_if.sink                samples,
	nsr_out_if.source             results
);

	nsr_cfg_t cfg_q;
	nsr_q_t   q;
	logic     pop;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frac_step  <= STEP_RESET;
			cfg_q.out_count  <= '0;
			cfg_q.in_wide    <= 1'b0;
			cfg_q.out_narrow <= 1'b0;
		end else if (cfg_we) begin
			case (nsr_reg_t'(cfg_index))
				REG_FRAC_STEP:  cfg_q.frac_step  <= cfg_data[STEP_W-1:0];
				REG_OUT_COUNT:  cfg_q.out_count  <= cfg_data[OUT_COUNT_W-1:0];
				REG_IN_WIDE:    cfg_q.in_wide    <= cfg_data[0];
				REG_OUT_NARROW: cfg_q.out_narrow <= cfg_data[0];
				default: ;
			endcase
		end
	end

	nsr_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.samples (samples),
		.q       (q),
		.pop     (pop)
	);

	nsr_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q       (q),
		.pop     (pop),
		.results (results)
	);

	// a sample is only retired when one is queued
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q.valid)
		else $error("retire with empty queue");

	// an accepted word is waiting in the queue on the next cycle
	a_accept_queues: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> q.valid)
		else $error("accepted word missing from queue");

	// with nothing queued the back end cannot start a new word
	a_no_word_without_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(!q.valid && !results.valid) |=> !results.valid)
		else $error("result word without a queued sample");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-sample resampler.
// ----------------------------------------------------------------------------
// Source words are driven on the samples channel and every result word is
// checked in order against a cycle-free model of the resampler held in a
// small scoreboard. A short directed run covers the sample extremes, both
// input formats, both output widths, a step below the minimum and the final
// word of a count. It is followed by randomised settings with up-, down- and
// unity resampling.
// Both channels idle at random. One phase runs with no idling at all, and
// one holds the receiver off long enough to back the block up. Registers
// change only once the block has gone quiet.
// ----------------------------------------------------------------------------

// model of the resampler plus the queue of result words still owed
class resample_scoreboard;

	localparam int unsigned MAX_WORDS  = 64;
	localparam int unsigned MAX_PRINTS = 40;

	typedef struct packed {
		logic signed [15:0] smp;
		logic               last;
	} word_t;

	// register copies
	logic [nsr_pkg::STEP_W-1:0]      step_reg;
	logic [nsr_pkg::OUT_COUNT_W-1:0] count_reg;
	logic                            wide_reg;
	logic                            narrow_reg;

	// stream state
	logic [nsr_pkg::OUT_COUNT_W-1:0]    src_index;
	logic [nsr_pkg::OUT_COUNT_W+15:0]   position;
	logic [nsr_pkg::OUT_COUNT_W-1:0]    emitted;

	word_t       expected_words[$];
	int unsigned errors;
	int unsigned words_checked;
	int unsigned samples_taken;
	int unsigned productive;

	function new();
		step_reg      = nsr_pkg::STEP_RESET;
		count_reg     = '0;
		wide_reg      = 1'b0;
		narrow_reg    = 1'b0;
		src_index     = '0;
		position      = '0;
		emitted       = '0;
		errors        = 0;
		words_checked = 0;
		samples_taken = 0;
		productive    = 0;
	endfunction

	task report(input string msg);
		if (errors < MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	// a register write lands at the same edge as in the block
	function void write_reg(input nsr_pkg::nsr_reg_t idx,
			input logic [nsr_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			nsr_pkg::REG_FRAC_STEP:  step_reg   = data[nsr_pkg::STEP_W-1:0];
			nsr_pkg::REG_OUT_COUNT:  count_reg  = data[nsr_pkg::OUT_COUNT_W-1:0];
			nsr_pkg::REG_IN_WIDE:    wide_reg   = data[0];
			nsr_pkg::REG_OUT_NARROW: narrow_reg = data[0];
			default: ;
		endcase
	endfunction

	// accepted source word: queue every result word it owes
	function int unsigned note_sample(input logic [15:0] raw);
		logic signed [15:0]         conv;
		logic [nsr_pkg::STEP_W-1:0] adv;
		word_t                      w;
		int unsigned                n;

		// widen to signed 16, 8-bit input is offset binary in the low byte
		if (wide_reg)
			conv = raw;
		else
			conv = {raw[7:0] ^ 8'h80, 8'h00};
		if (narrow_reg)
			conv = conv >>> 8;

		adv = (step_reg < nsr_pkg::STEP_MIN) ? nsr_pkg::STEP_MIN : step_reg;
		n   = 0;
		while (n < MAX_WORDS && emitted < count_reg
				&& position[nsr_pkg::OUT_COUNT_W+15:8] == 32'(src_index)) begin
			emitted  = emitted + 1'b1;
			position = position + (nsr_pkg::OUT_COUNT_W+16)'(adv);
			w.smp    = conv;
			w.last   = (emitted == count_reg);
			expected_words.push_back(w);
			n++;
		end
		src_index = src_index + 1'b1;
		samples_taken++;
		if (n != 0)
			productive++;
		return n;
	endfunction

	// accepted result word against the oldest one owed
	task check_word(input logic signed [15:0] smp, input logic last);
		word_t want;

		if (expected_words.size() == 0) begin
			report($sformatf("word %0d last %0b with nothing owed", smp, last));
			return;
		end
		want = expected_words.pop_front();
		words_checked++;
		if (smp !== want.smp)
			report($sformatf("word %0d: out_sample %0d, want %0d",
				words_checked, smp, want.smp));
		if (last !== want.last)
			report($sformatf("word %0d: last %0b, want %0b",
				words_checked, last, want.last));
	endtask

endclass

module tb_top;
	import nsr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned IDLE_PCT      = 24;
	localparam int unsigned RAND_PHASES   = 6;
	localparam logic [OUT_COUNT_W-1:0] COUNT_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// idling controls shared with the receiver
	bit calm;
	bit hold_req;

	int unsigned settings_used;

	resample_scoreboard sb = new();

	nsr_in_if  samples_if ();
	nsr_out_if results_if ();

	nearest_sample_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.results   (results_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// words are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_word(results_if.out_sample, results_if.last);
		if (arst_n && samples_if.valid && samples_if.ready)
			void'(sb.note_sample(samples_if.in_sample));
	end

	// receiver: random stalls, a long hold-off on request
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			results_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// overall time limit
	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// one register write; the caller drops cfg_we afterwards
	task automatic write_reg(input nsr_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// full register set, junk in the unused upper bits
	task automatic program_regs(input logic [STEP_W-1:0] adv,
			input logic [OUT_COUNT_W-1:0] count, input logic wide, input logic narrow);
		write_reg(REG_FRAC_STEP, {8'($urandom), adv});
		write_reg(REG_OUT_COUNT, count);
		write_reg(REG_IN_WIDE, {23'($urandom), wide});
		write_reg(REG_OUT_NARROW, {23'($urandom), narrow});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// offer one source word; valid is left high for back-to-back words
	task automatic send_word(input logic [15:0] smp);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.in_sample <= smp;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random words until enough give output, the cap is hit or the count is spent
	task automatic run_phase(input int unsigned target, input int unsigned cap,
			input bit until_count);
		int unsigned useful;
		int unsigned sent;
		int unsigned prev;

		useful = 0;
		sent   = 0;
		while (useful < target && sent < cap
				&& !(until_count && sb.emitted >= sb.count_reg)) begin
			prev = sb.productive;
			send_word(16'($urandom));
			sent++;
			if (sb.productive != prev)
				useful++;
		end
		samples_if.valid <= 1'b0;
	endtask

	// everything owed has arrived and the queue has run dry
	task automatic settle();
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// main sequence
	initial begin
		logic [15:0]            wide_words[5];
		logic [15:0]            byte_words[5];
		logic [STEP_W-1:0]      adv;
		logic [OUT_COUNT_W-1:0] count;
		logic                   wide;
		logic                   narrow;
		int unsigned            target;
		int unsigned            cap;
		bit                     until_count;

		wide_words = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};
		byte_words = '{16'h0000, 16'h00FF, 16'hFF80, 16'h007F, 16'hAB01};

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_FRAC_STEP;
		cfg_data             = '0;
		samples_if.valid     = 1'b0;
		samples_if.in_sample = '0;
		calm                 = 1'b0;
		hold_req             = 1'b0;
		settings_used        = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 16-bit extremes at unity step
		program_regs(STEP_RESET, COUNT_MAX, 1'b1, 1'b0);
		foreach (wide_words[i])
			send_word(wide_words[i]);
		samples_if.valid <= 1'b0;
		settle();

		// 8-bit extremes, upper byte junk, 2x up, narrowed output
		program_regs(16'd128, COUNT_MAX, 1'b0, 1'b1);
		foreach (byte_words[i])
			send_word(byte_words[i]);
		samples_if.valid <= 1'b0;
		settle();

		// step below the minimum: 64 words per source word
		program_regs(16'd1, COUNT_MAX, 1'b1, 1'b1);
		send_word(16'h8000);
		send_word(16'h7FFF);
		samples_if.valid <= 1'b0;
		settle();

		// count ends on a word boundary, final word flagged
		program_regs(STEP_RESET, sb.emitted + 24'd3, 1'b0, 1'b0);
		send_word(16'h1280);
		send_word(16'h00AA);
		send_word(16'hFF55);
		samples_if.valid <= 1'b0;
		settle();

		// random settings
		for (int p = 0; p < RAND_PHASES; p++) begin
			wide        = 1'($urandom);
			narrow      = 1'($urandom);
			count       = ($urandom_range(3) == 0) ? sb.emitted + 24'($urandom_range(5000, 9000))
				: COUNT_MAX;
			until_count = 1'b0;
			cap         = 2000;
			case (p % 6)
				0: begin
					adv    = 16'($urandom_range(3));
					target = 8;
				end
				1: begin
					adv    = (p == 1) ? STEP_MIN : 16'($urandom_range(5, 255));
					target = 30;
				end
				2: begin
					adv    = STEP_RESET;
					target = 30;
				end
				3: begin
					adv    = 16'($urandom_range(257, 2048));
					target = 12;
				end
				4: begin
					// at most one word per source word, so the count stops cleanly
					adv         = 16'($urandom_range(256, 1024));
					count       = sb.emitted + 24'($urandom_range(10, 30));
					until_count = 1'b1;
					target      = 100;
				end
				default: begin
					adv    = 16'($urandom_range(2049, 4096));
					target = 3;
					cap    = 100;
				end
			endcase
			program_regs(adv, count, wide, narrow);
			calm     = (p == 2);
			hold_req = (p == 1);
			run_phase(target, cap, until_count);
			settle();
			calm = 1'b0;
		end

		// count runs out part way through a source word
		program_regs(16'd64, sb.emitted + 24'd6, 1'b1, 1'b0);
		run_phase(100, 100, 1'b1);
		settle();

		// count lowered below what is already out, then zero: silence
		program_regs(STEP_RESET, sb.emitted - 24'd2, 1'b0, 1'b1);
		run_phase(1, 4, 1'b0);
		settle();
		program_regs(STEP_RESET, '0, 1'b1, 1'b1);
		run_phase(1, 3, 1'b0);
		settle();

		$display("summary: %0d source words, %0d result words checked, %0d register settings",
			sb.samples_taken, sb.words_checked, settings_used);
		$display("summary: both formats and widths, steps 1 to 4096, count stops, hold-off");
		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
src/nsr_pkg.sv
src/nsr_if.sv
src/nsr_front.sv
src/nsr_back.sv
src/nearest_sample_resampler.sv
dv/tb_top.sv
